### hw/rtl/netstring_deframer_top_assert.svh
// assertion macros for the netstring deframer checker
`ifndef NETSTRING_DEFRAMER_TOP_ASSERT_SVH
`define NETSTRING_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define NSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("nsd same-cycle check failed");

// next-cycle implication
`define NSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("nsd next-cycle check failed");

`endif

### hw/rtl/nsd_pkg.sv
`timescale 1ns / 1ps
package nsd_pkg;

    localparam int MAX_HEADER_BYTES_DEF = 21;
    localparam int LENGTH_WIDTH_DEF     = 32;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int MLEN_W = 32;
    localparam int CFG_W  = 32;

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 32'd4096;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_BYTE = 2'd0,
        K_DONE = 2'd1,
        K_BAD  = 2'd2,
        K_LONG = 2'd3
    } t_kind;

    // word held in the input register
    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } t_byte_word;

endpackage

### hw/rtl/nsd_if.sv
`timescale 1ns / 1ps
interface nsd_rx_if;
    import nsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsd_res_if;
    import nsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [MLEN_W-1:0] message_length;

    modport source (output valid, output kind, output payload_byte, output message_length,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input message_length,
                    output ready);
endinterface

### hw/rtl/netstring_deframer_top.sv
`timescale 1ns / 1ps
// Netstring deframer: takes one received byte per word on i_rx and returns at most one
// result word on o_res (payload byte, message complete with its declared length,
// ill-formed, or too long); digits and an accepted colon give no result. It takes a
// byte every cycle while o_res keeps up: the byte sits in an input register, then
// the header check, multiply-by-ten add and count logic update the frame state and
// load the result register, from which the result is valid on o_res. Input ready
// drops only while the result register holds a word that o_res does not take. Write
// max_payload through i_cfg_we / i_cfg_wdata only while the block is idle.
module netstring_deframer_top #(
    parameter int MAX_HEADER_BYTES = nsd_pkg::MAX_HEADER_BYTES_DEF,
    parameter int LENGTH_WIDTH     = nsd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nsd_pkg::CFG_W-1:0] i_cfg_wdata,
    nsd_rx_if.sink                    i_rx,
    nsd_res_if.source                 o_res
);
    import nsd_pkg::*;

    logic [CFG_W-1:0] r_max_payload;
    t_byte_word       w_word;
    logic             w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    nsd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_word  (w_word)
    );

    nsd_engine #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .LENGTH_WIDTH     (LENGTH_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (w_word),
        .i_max_payload (r_max_payload),
        .o_take        (w_take),
        .o_res         (o_res)
    );

endmodule

### hw/rtl/nsd_in_stage.sv
`timescale 1ns / 1ps
module nsd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    nsd_rx_if.sink              i_rx,
    input  logic                i_take,
    output nsd_pkg::t_byte_word o_word
);
    import nsd_pkg::*;

    logic              r_vld;
    logic [BYTE_W-1:0] r_data;
    logic              w_load;

    // register is free when empty or being drained this cycle
    assign w_load     = !r_vld || i_take;
    assign i_rx.ready = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_rx.valid) begin
            r_data <= i_rx.rx_byte;
        end
    end

    assign o_word.vld  = r_vld;
    assign o_word.data = r_data;

endmodule

### hw/rtl/nsd_engine.sv
`timescale 1ns / 1ps
module nsd_engine #(
    parameter int MAX_HEADER_BYTES = nsd_pkg::MAX_HEADER_BYTES_DEF,
    parameter int LENGTH_WIDTH     = nsd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsd_pkg::t_byte_word       i_word,
    input  logic [nsd_pkg::CFG_W-1:0] i_max_payload,
    output logic                      o_take,
    nsd_res_if.source                 o_res
);
    import nsd_pkg::*;

    localparam int HCW   = $clog2(MAX_HEADER_BYTES + 1);
    localparam int LW    = LENGTH_WIDTH;
    localparam int CMP_W = (LW > CFG_W) ? LW : CFG_W;

    t_phase            r_phase, n_phase;
    logic [HCW-1:0]    r_cnt, n_cnt;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_rem, n_rem;

    logic              r_out_vld;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic [MLEN_W-1:0] r_out_len;

    logic              w_fire;
    logic              w_res_vld;
    t_kind             w_res_kind;
    logic [BYTE_W-1:0] w_res_byte;
    logic [MLEN_W-1:0] w_res_len;

    logic              w_is_digit;
    logic              w_is_colon;
    logic [3:0]        w_digit;
    logic [HCW-1:0]    w_cnt_inc;
    logic [LW+3:0]     w_acc;
    logic [LW-1:0]     w_acc_sat;
    logic [CMP_W-1:0]  w_len_ext;
    logic [CMP_W-1:0]  w_max_ext;

    assign w_fire = i_word.vld && (!r_out_vld || o_res.ready);
    assign o_take = w_fire;

    assign w_is_digit = (i_word.data >= CH_ZERO) && (i_word.data <= CH_NINE);
    assign w_is_colon = (i_word.data == CH_COLON);
    assign w_digit    = 4'(i_word.data - CH_ZERO);
    assign w_cnt_inc  = r_cnt + HCW'(1);

    // len*10 + digit as (len<<3) + (len<<1) + digit, clamped to all ones
    assign w_acc = (LW+4)'({r_len, 3'b000}) + (LW+4)'({r_len, 1'b0}) + (LW+4)'(w_digit);
    assign w_acc_sat = (w_acc > (LW+4)'({LW{1'b1}})) ? {LW{1'b1}} : w_acc[LW-1:0];

    assign w_len_ext = CMP_W'(r_len);
    assign w_max_ext = CMP_W'(i_max_payload);

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_rem      = r_rem;
        w_res_vld  = 1'b0;
        w_res_kind = K_BYTE;
        w_res_byte = '0;
        w_res_len  = '0;
        case (r_phase)
            PH_PAYLOAD: begin
                n_rem      = r_rem - LW'(1);
                if (n_rem == '0) begin
                    n_phase = PH_TRAILER;
                end
                w_res_vld  = 1'b1;
                w_res_kind = K_BYTE;
                w_res_byte = i_word.data;
            end
            PH_TRAILER: begin
                n_phase   = PH_HEADER;
                n_cnt     = '0;
                n_len     = '0;
                n_rem     = '0;
                w_res_vld = 1'b1;
                if (i_word.data == CH_COMMA) begin
                    w_res_kind = K_DONE;
                    w_res_len  = w_len_ext[MLEN_W-1:0];
                end else begin
                    w_res_kind = K_BAD;
                end
            end
            default: begin
                // header phase, unused code lands here too
                if ((!w_is_digit && !w_is_colon) ||
                    (w_cnt_inc >= HCW'(MAX_HEADER_BYTES))) begin
                    n_phase    = PH_HEADER;
                    n_cnt      = '0;
                    n_len      = '0;
                    n_rem      = '0;
                    w_res_vld  = 1'b1;
                    w_res_kind = K_BAD;
                end else if (w_is_digit) begin
                    n_cnt = w_cnt_inc;
                    n_len = w_acc_sat;
                end else if (w_len_ext > w_max_ext) begin
                    n_phase    = PH_HEADER;
                    n_cnt      = '0;
                    n_len      = '0;
                    n_rem      = '0;
                    w_res_vld  = 1'b1;
                    w_res_kind = K_LONG;
                end else begin
                    n_cnt   = '0;
                    n_rem   = r_len;
                    n_phase = (r_len == '0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_cnt     <= '0;
            r_len     <= '0;
            r_rem     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase   <= n_phase;
                r_cnt     <= n_cnt;
                r_len     <= n_len;
                r_rem     <= n_rem;
                r_out_vld <= w_res_vld;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_vld) begin
            r_out_kind <= w_res_kind;
            r_out_byte <= w_res_byte;
            r_out_len  <= w_res_len;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.kind           = r_out_kind;
    assign o_res.payload_byte   = r_out_byte;
    assign o_res.message_length = r_out_len;

endmodule

### hw/rtl/nsd_checker.sv
`timescale 1ns / 1ps
`include "netstring_deframer_top_assert.svh"
module nsd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [nsd_pkg::KIND_W-1:0] i_res_kind,
    input logic [nsd_pkg::BYTE_W-1:0] i_res_payload_byte,
    input logic [nsd_pkg::MLEN_W-1:0] i_res_message_length
);
    import nsd_pkg::*;

    // payload byte is zero on every word that is not a payload byte
    `NSD_ASSERT_NOW(a_byte_zero, i_res_valid && (i_res_kind != K_BYTE), i_res_payload_byte == '0)

    // length is zero on every word that is not a completion
    `NSD_ASSERT_NOW(a_len_zero, i_res_valid && (i_res_kind != K_DONE), i_res_message_length == '0)

    // a stalled result word stays put
    `NSD_ASSERT_NEXT(a_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_kind) && $stable(i_res_payload_byte) && $stable(i_res_message_length))

endmodule

bind netstring_deframer_top nsd_checker u_nsd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_res_valid          (o_res.valid),
    .i_res_ready          (o_res.ready),
    .i_res_kind           (o_res.kind),
    .i_res_payload_byte   (o_res.payload_byte),
    .i_res_message_length (o_res.message_length)
);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import nsd_pkg::*;

    typedef struct {
        t_kind             kind;
        logic [BYTE_W-1:0] pb;
        logic [MLEN_W-1:0] len;
    } deframe_res_t;

    // directed stimulus row: typed rows carry their own expected result
    typedef struct {
        logic [BYTE_W-1:0] b;
        int                reps;
        bit                typed;
        bit                has;
        t_kind             kind;
        logic [MLEN_W-1:0] len;
    } dir_row_t;

    localparam int NUM_DIR = 28;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;

    nsd_rx_if  rx_ch ();
    nsd_res_if res_ch ();

    netstring_deframer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    // frame tracker state
    t_phase            ph;
    logic [4:0]        hdr_cnt;
    logic [MLEN_W-1:0] decl;
    logic [MLEN_W-1:0] remain;
    logic [CFG_W-1:0]  max_pl;

    deframe_res_t      pending_results [$];
    deframe_res_t      want_res;
    logic [BYTE_W-1:0] tx_bytes [$];
    dir_row_t          dir_tab [NUM_DIR];
    int                n_err;
    bit                calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        n_err++;
    endtask

    function automatic void frame_restart();
        ph      = PH_HEADER;
        hdr_cnt = '0;
        decl    = '0;
        remain  = '0;
    endfunction

    function automatic bit deframe_step(input logic [BYTE_W-1:0] b, output deframe_res_t r);
        logic [63:0] acc;
        bit          is_dig;
        bit          is_col;
        r.kind = K_BYTE;
        r.pb   = '0;
        r.len  = '0;
        case (ph)
            PH_PAYLOAD: begin
                remain = remain - 1;
                if (remain == 0) ph = PH_TRAILER;
                r.pb = b;
                return 1'b1;
            end
            PH_TRAILER: begin
                if (b == CH_COMMA) begin
                    r.kind = K_DONE;
                    r.len  = decl;
                end else begin
                    r.kind = K_BAD;
                end
                frame_restart();
                return 1'b1;
            end
            default: begin
                is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
                is_col = (b == CH_COLON);
                if (!is_dig && !is_col) begin
                    frame_restart();
                    r.kind = K_BAD;
                    return 1'b1;
                end
                hdr_cnt = hdr_cnt + 1;
                if (hdr_cnt >= MAX_HEADER_BYTES_DEF) begin
                    frame_restart();
                    r.kind = K_BAD;
                    return 1'b1;
                end
                if (is_dig) begin
                    // length saturates at all ones
                    acc  = 64'(decl) * 64'd10 + 64'(b) - 64'(CH_ZERO);
                    decl = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
                    return 1'b0;
                end
                if (decl > max_pl) begin
                    frame_restart();
                    r.kind = K_LONG;
                    return 1'b1;
                end
                hdr_cnt = '0;
                remain  = decl;
                ph      = (decl == 0) ? PH_TRAILER : PH_PAYLOAD;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input bit t_has,
                             input deframe_res_t t_res);
        int           gap;
        bit           got;
        deframe_res_t p;
        gap = pick_gap();
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        got = deframe_step(b, p);
        if (typed) begin
            got = t_has;
            p   = t_res;
        end
        if (got) pending_results.push_back(p);
    endtask

    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // digits and colons give no word, so let the pipeline empty
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        max_pl = v;
    endtask

    task automatic push_decimal(input longint unsigned v, input int nz);
        logic [BYTE_W-1:0] digs [$];
        longint unsigned   x;
        repeat (nz) tx_bytes.push_back(CH_ZERO);
        x = v;
        do begin
            digs.push_front(CH_ZERO + 8'(x % 10));
            x = x / 10;
        end while (x != 0);
        foreach (digs[i]) tx_bytes.push_back(digs[i]);
    endtask

    task automatic gen_frame();
        int                mode;
        int                r;
        int                len;
        int                nz;
        longint unsigned   v;
        logic [BYTE_W-1:0] c;
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            r   = $urandom_range(0, 99);
            len = (r < 70) ? $urandom_range(0, 6) :
                  (r < 95) ? $urandom_range(7, 30) : $urandom_range(31, 80);
            if (len > max_pl) len = max_pl;
            nz = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
            push_decimal(len, nz);
            tx_bytes.push_back(CH_COLON);
            repeat (len) tx_bytes.push_back(8'($urandom_range(0, 255)));
            if (mode < 62) begin
                tx_bytes.push_back(CH_COMMA);
            end else begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_COMMA) c = 8'h2D;
                tx_bytes.push_back(c);
            end
        end else if (mode < 78) begin
            // over the limit, sometimes far enough to saturate
            v = 64'(max_pl) + 64'd1;
            if ($urandom_range(0, 3) == 0) v = v + 64'($urandom) * 64'($urandom_range(1, 5000));
            else v = v + 64'($urandom_range(0, 20));
            push_decimal(v, 0);
            tx_bytes.push_back(CH_COLON);
        end else if (mode < 86) begin
            repeat ($urandom_range(0, 3)) tx_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            do c = 8'($urandom_range(0, 255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COLON);
            tx_bytes.push_back(c);
        end else if (mode < 92) begin
            // headers around the byte count limit
            repeat ($urandom_range(18, 21)) tx_bytes.push_back(CH_ZERO);
            tx_bytes.push_back(CH_COLON);
            tx_bytes.push_back(CH_COMMA);
        end else begin
            repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int budget, input bit pause_mid);
        int                sent;
        bit                paused;
        deframe_res_t      none_res;
        logic [BYTE_W-1:0] b;
        sent          = 0;
        paused        = 1'b0;
        none_res.kind = K_BYTE;
        none_res.pb   = '0;
        none_res.len  = '0;
        while (sent < budget) begin
            gen_frame();
            while (tx_bytes.size() > 0) begin
                b = tx_bytes.pop_front();
                send_byte(b, 1'b0, 1'b0, none_res);
                sent++;
            end
            if (pause_mid && !paused && sent >= budget / 2) begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(0, 29) == 0) calm = !calm;
        end
    endtask

    // result side stalls
    initial begin
        int hold;
        bit rdy;
        hold = 0;
        rdy  = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                if (calm || $urandom_range(0, 1) == 1) begin
                    rdy  = 1'b1;
                    hold = $urandom_range(1, 12);
                end else begin
                    rdy  = 1'b0;
                    hold = pick_gap() + 1;
                end
            end
            hold--;
            res_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d", res_ch.kind));
            end else begin
                want_res = pending_results.pop_front();
                if (res_ch.kind !== want_res.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", res_ch.kind,
                                              want_res.kind));
                if (res_ch.payload_byte !== want_res.pb)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              res_ch.payload_byte, want_res.pb));
                if (res_ch.message_length !== want_res.len)
                    report_mismatch($sformatf("message_length %0d, want %0d",
                                              res_ch.message_length, want_res.len));
            end
        end
    end

    initial begin
        deframe_res_t row_res;
        n_err = 0;
        calm  = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        frame_restart();
        max_pl = MAX_PAYLOAD_RST;

        dir_tab = '{
            '{CH_COLON,        1,  1'b1, 1'b0, K_BYTE, 32'd0},
            '{CH_COMMA,        1,  1'b1, 1'b1, K_DONE, 32'd0},
            '{8'h78,           1,  1'b1, 1'b1, K_BAD,  32'd0},
            '{8'h2F,           1,  1'b1, 1'b1, K_BAD,  32'd0},
            '{8'h3B,           1,  1'b1, 1'b1, K_BAD,  32'd0},
            '{8'hFF,           1,  1'b1, 1'b1, K_BAD,  32'd0},
            '{CH_ZERO + 8'd3,  1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COLON,        1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{8'h00,           1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{8'hFF,           1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{8'hA5,           1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COMMA,        1,  1'b1, 1'b1, K_DONE, 32'd3},
            '{CH_ZERO + 8'd4,  1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_ZERO,         1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_NINE,         1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_ZERO + 8'd7,  1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COLON,        1,  1'b1, 1'b1, K_LONG, 32'd0},
            '{CH_ZERO + 8'd1,  1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COLON,        1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{8'h41,           1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{8'h2E,           1,  1'b1, 1'b1, K_BAD,  32'd0},
            '{CH_ZERO,         20, 1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COLON,        1,  1'b1, 1'b1, K_BAD,  32'd0},
            '{CH_ZERO,         19, 1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COLON,        1,  1'b0, 1'b0, K_BYTE, 32'd0},
            '{CH_COMMA,        1,  1'b1, 1'b1, K_DONE, 32'd0},
            '{CH_NINE,         12, 1'b0, 1'b0, K_BYTE, 32'd0},
            '{8'h3B,           1,  1'b1, 1'b1, K_BAD,  32'd0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            row_res.kind = dir_tab[i].kind;
            row_res.pb   = '0;
            row_res.len  = dir_tab[i].len;
            repeat (dir_tab[i].reps)
                send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].has, row_res);
        end
        drain();

        run_random(150, 1'b0);
        drain();
        write_max(32'd1);
        run_random(150, 1'b0);
        drain();
        write_max(32'hFFFF_FFFE);
        run_random(150, 1'b0);
        drain();
        write_max(32'($urandom_range(2, 40)));
        run_random(200, 1'b1);
        drain();
        write_max(MAX_PAYLOAD_RST);
        run_random(150, 1'b0);
        drain();

        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
